[hdl/ecal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ecal_pkg;

  localparam int TS_BITS   = 40;
  localparam int DAYS_W    = TS_BITS - 16;
  localparam int CYC_W     = DAYS_W - 17;
  localparam int DIVR_W    = 18;
  localparam int YEAR_W    = 16;
  localparam int SOD_W     = 17;
  localparam int Y400_W    = 9;
  localparam int DAY_POW2  = 7;
  localparam int MULA_W    = TS_BITS - DAY_POW2;
  localparam int RECIP_W   = DAYS_W;
  localparam int PROD_W    = MULA_W + RECIP_W;
  localparam int BACK_W    = DAYS_W + DIVR_W;
  localparam int REM_W     = DIVR_W + 1;
  localparam int DAY_SHIFT = MULA_W;
  localparam int CYC_SHIFT = DAYS_W + DAY_POW2;

  // 86400 = 675 << 7
  localparam logic [DIVR_W-1:0]  DAY_ODD        = DIVR_W'(86400 >> DAY_POW2);
  localparam logic [DIVR_W-1:0]  DAYS_PER_CYCLE = 18'd146097;
  localparam logic [RECIP_W-1:0] RECIP_DAY      = RECIP_W'((64'd1 << DAY_SHIFT) / 64'(DAY_ODD));
  localparam logic [RECIP_W-1:0] RECIP_CYC      = RECIP_W'((64'd1 << CYC_SHIFT)
                                                           / 64'(DAYS_PER_CYCLE));
  localparam logic [SOD_W-1:0]   SECS_PER_HOUR  = 17'd3600;
  localparam logic [SOD_W-1:0]   SECS_PER_MIN   = 17'd60;
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR     = 16'd1970;
  localparam logic [Y400_W-1:0]  EPOCH_Y400     = 9'd370;
  localparam logic [Y400_W-1:0]  Y400_LAST      = 9'd399;
  localparam logic [3:0]         LAST_MONTH     = 4'd12;

  typedef struct packed {
    logic start_day;
    logic start_cyc;
    logic init_year;
    logic year_step;
    logic month_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic year_done;
    logic month_done;
    logic tod_done;
  } status_t;

  typedef struct packed {
    logic                start;
    logic                by_cycle;
    logic [TS_BITS-1:0]  dividend;
  } div_req_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    unique case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[hdl/ecal_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module ecal_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ecal_pkg::div_req_t              req,
  output logic                                 busy,
  output logic [ecal_pkg::DAYS_W-1:0]          quot,
  output logic [ecal_pkg::DIVR_W-1:0]          rem
);

  typedef enum logic [1:0] {
    PH_MUL,
    PH_EST,
    PH_BACK,
    PH_FIX
  } phase_t;

  phase_t                          phase;
  logic                            by_cycle;
  logic [ecal_pkg::TS_BITS-1:0]    x;
  logic [ecal_pkg::PROD_W-1:0]     prod;
  logic [ecal_pkg::DAYS_W-1:0]     q;
  logic [ecal_pkg::REM_W-1:0]      r;
  logic [ecal_pkg::MULA_W-1:0]     mul_a;
  logic [ecal_pkg::RECIP_W-1:0]    mul_b;
  logic [ecal_pkg::DIVR_W-1:0]     d;
  logic [ecal_pkg::DAYS_W-1:0]     q_est;
  logic [ecal_pkg::BACK_W-1:0]     back;
  logic [ecal_pkg::BACK_W-1:0]     diff;
  logic                            r_ge;

  // constant division by reciprocal, estimate is exact or one low
  // day: t / 86400 = (t >> 7) / 675, cycle: days / 146097
  always_comb begin
    mul_a = by_cycle ? ecal_pkg::MULA_W'(x[ecal_pkg::DAYS_W-1:0])
                     : x[ecal_pkg::TS_BITS-1:ecal_pkg::DAY_POW2];
    mul_b = by_cycle ? ecal_pkg::RECIP_CYC : ecal_pkg::RECIP_DAY;
    d     = by_cycle ? ecal_pkg::DAYS_PER_CYCLE : ecal_pkg::DAY_ODD;
    q_est = by_cycle ? ecal_pkg::DAYS_W'(prod[ecal_pkg::CYC_SHIFT +: ecal_pkg::CYC_W])
                     : prod[ecal_pkg::DAY_SHIFT +: ecal_pkg::DAYS_W];
    back  = ecal_pkg::BACK_W'(q) * ecal_pkg::BACK_W'(d);
    diff  = ecal_pkg::BACK_W'(mul_a) - back;
    r_ge  = r >= ecal_pkg::REM_W'(d);
    quot  = q;
    rem   = by_cycle ? r[ecal_pkg::DIVR_W-1:0]
                     : ecal_pkg::DIVR_W'({r[ecal_pkg::SOD_W-ecal_pkg::DAY_POW2-1:0],
                                          x[ecal_pkg::DAY_POW2-1:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_MUL;
    end else if (req.start) begin
      x        <= req.dividend;
      by_cycle <= req.by_cycle;
      phase    <= PH_MUL;
      busy     <= 1'b1;
    end else if (busy) begin
      unique case (phase)
        PH_MUL: begin
          prod  <= ecal_pkg::PROD_W'(mul_a) * ecal_pkg::PROD_W'(mul_b);
          phase <= PH_EST;
        end
        PH_EST: begin
          q     <= q_est;
          phase <= PH_BACK;
        end
        PH_BACK: begin
          r     <= diff[ecal_pkg::REM_W-1:0];
          phase <= PH_FIX;
        end
        PH_FIX: begin
          if (r_ge) begin
            r <= r - ecal_pkg::REM_W'(d);
            q <= q + 1'b1;
          end
          busy  <= 1'b0;
          phase <= PH_MUL;
        end
        default: phase <= PH_MUL;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/ecal_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module ecal_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ecal_pkg::cmd_t               cmd,
  input  wire logic [ecal_pkg::TS_BITS-1:0] epoch_seconds,
  output ecal_pkg::status_t                 st,
  output logic [15:0]                       year,
  output logic [3:0]                        month,
  output logic [4:0]                        day_of_month,
  output logic [4:0]                        hour,
  output logic [5:0]                        minute,
  output logic [5:0]                        second
);

  ecal_pkg::div_req_t             req;
  logic                           div_busy;
  logic [ecal_pkg::DAYS_W-1:0]    quot;
  logic [ecal_pkg::DIVR_W-1:0]    rem;

  logic [ecal_pkg::DIVR_W-1:0]    days_r;
  logic [ecal_pkg::YEAR_W-1:0]    year_r;
  logic [ecal_pkg::Y400_W-1:0]    y400;
  logic [3:0]                     month_r;
  logic [ecal_pkg::SOD_W-1:0]     sod_r;
  logic [4:0]                     hour_r;
  logic [5:0]                     min_r;

  logic [ecal_pkg::YEAR_W-1:0]    cyc;
  logic                           leap;
  logic [8:0]                     ylen;
  logic [4:0]                     mlen;
  logic                           year_ge;
  logic                           month_go;
  logic                           hr_go;
  logic                           min_go;

  always_comb begin
    req.start    = cmd.start_day | cmd.start_cyc;
    req.by_cycle = cmd.start_cyc;
    req.dividend = cmd.start_day ? epoch_seconds : ecal_pkg::TS_BITS'(quot);
  end

  ecal_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .busy (div_busy),
    .quot (quot),
    .rem  (rem)
  );

  always_comb begin
    cyc      = ecal_pkg::YEAR_W'(quot[ecal_pkg::CYC_W-1:0]);
    leap     = (y400[1:0] == 2'd0) && !(y400 == 9'd100 || y400 == 9'd200 || y400 == 9'd300);
    ylen     = leap ? 9'd366 : 9'd365;
    mlen     = ecal_pkg::month_days(month_r, leap);
    year_ge  = days_r >= ecal_pkg::DIVR_W'(ylen);
    month_go = (month_r != ecal_pkg::LAST_MONTH) && (days_r >= ecal_pkg::DIVR_W'(mlen));
    hr_go    = sod_r >= ecal_pkg::SECS_PER_HOUR;
    min_go   = !hr_go && (sod_r >= ecal_pkg::SECS_PER_MIN);
    st.div_busy   = div_busy;
    st.year_done  = !year_ge;
    st.month_done = !month_go;
    st.tod_done   = !hr_go && !min_go;
  end

  always_ff @(posedge clk) begin
    // 400-year cycles fold into the year, the rest walks year by year
    if (cmd.init_year) begin
      year_r  <= ecal_pkg::EPOCH_YEAR + (cyc << 8) + (cyc << 7) + (cyc << 4);
      days_r  <= rem;
      y400    <= ecal_pkg::EPOCH_Y400;
      month_r <= 4'd1;
    end else if (cmd.year_step && year_ge) begin
      days_r <= days_r - ecal_pkg::DIVR_W'(ylen);
      year_r <= year_r + 1'b1;
      y400   <= (y400 == ecal_pkg::Y400_LAST) ? '0 : y400 + 1'b1;
    end else if (cmd.month_step && month_go) begin
      days_r  <= days_r - ecal_pkg::DIVR_W'(mlen);
      month_r <= month_r + 1'b1;
    end

    // time of day runs alongside the year walk
    if (cmd.start_cyc) begin
      sod_r  <= rem[ecal_pkg::SOD_W-1:0];
      hour_r <= '0;
      min_r  <= '0;
    end else if (hr_go) begin
      sod_r  <= sod_r - ecal_pkg::SECS_PER_HOUR;
      hour_r <= hour_r + 1'b1;
    end else if (min_go) begin
      sod_r <= sod_r - ecal_pkg::SECS_PER_MIN;
      min_r <= min_r + 1'b1;
    end

    if (cmd.emit) begin
      year         <= year_r;
      month        <= month_r;
      day_of_month <= days_r[4:0] + 5'd1;
      hour         <= hour_r;
      minute       <= min_r;
      second       <= sod_r[5:0];
    end
  end

endmodule
`default_nettype wire

[hdl/ecal_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module ecal_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ecal_pkg::status_t st,
  output ecal_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DIV_DAY,
    DIV_CYC,
    YEARS,
    MONTHS
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd.start_day  = in_valid && in_ready;
    cmd.start_cyc  = (state == DIV_DAY) && !st.div_busy;
    cmd.init_year  = (state == DIV_CYC) && !st.div_busy;
    cmd.year_step  = (state == YEARS);
    cmd.month_step = (state == MONTHS);
    cmd.emit       = (state == MONTHS) && st.month_done && st.tod_done
                     && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE:    if (cmd.start_day) state_next = DIV_DAY;
      DIV_DAY: if (cmd.start_cyc) state_next = DIV_CYC;
      DIV_CYC: if (cmd.init_year) state_next = YEARS;
      YEARS:   if (st.year_done) state_next = MONTHS;
      MONTHS:  if (cmd.emit) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_when_done: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (st.year_done && st.month_done && st.tod_done && !st.div_busy))
    else $error("result emitted before datapath finished");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  a_start_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == DIV_DAY && st.div_busy))
    else $error("day division did not start on request");

endmodule
`default_nettype wire

[hdl/epoch_seconds_to_calendar_top.sv]
// sequence: day and cycle divisions, then Y year steps past the last 400-year
//   boundary from 1970 (0..399), then M month steps (0..11); S hour plus minute steps
//   (0..82) run alongside; the result waits while a held result blocks the output
// throughput: one request at a time, two constant divisions then the one-year-per-cycle
//   walk; next request taken the cycle after the result is registered
// reset: clears controller state, divider busy and output valid, no result pending
`timescale 1ns / 1ps
`default_nettype none
module epoch_seconds_to_calendar_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [39:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day_of_month,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second
);

  ecal_pkg::cmd_t    cmd;
  ecal_pkg::status_t st;

  ecal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ecal_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .epoch_seconds (epoch_seconds[ecal_pkg::TS_BITS-1:0]),
    .st            (st),
    .year          (year),
    .month         (month),
    .day_of_month  (day_of_month),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule
`default_nettype wire

[tb/tb_epoch_seconds_to_calendar_top.sv]
`timescale 1ns / 1ps
module tb_epoch_seconds_to_calendar_top;

  localparam int N_RANDOM   = 1130;
  localparam int HOLD_AT    = 150;
  localparam int HOLD_LEN   = 400;
  localparam int PAUSE_AT   = 700;
  localparam int DRAIN_WAIT = 600;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [39:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  logic [39:0] timestamp_backlog [$];
  calendar_t   pending_dates [$];
  int          stim_total = 1;
  int          requests_sent = 0;
  int          dates_received = 0;
  int          mismatches = 0;
  int          hold_left = HOLD_LEN;
  bit          req_taken = 1'b0;
  bit          pause_done = 1'b0;

  epoch_seconds_to_calendar_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .epoch_seconds(epoch_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  function automatic bit year_is_leap(input longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned month_length(input int unsigned mon, input bit leap);
    case (mon)
      4, 6, 9, 11: return 30;
      2:           return leap ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic calendar_t seconds_to_date(input logic [39:0] secs);
    longint unsigned t;
    longint unsigned days;
    longint unsigned sod;
    longint unsigned yr;
    int unsigned     mon;
    calendar_t       d;
    t    = secs;
    days = t / 86400;
    sod  = t % 86400;
    yr   = 1970 + (days / 146097) * 400;
    days = days % 146097;
    while (days >= (year_is_leap(yr) ? 366 : 365)) begin
      days -= year_is_leap(yr) ? 366 : 365;
      yr++;
    end
    mon = 1;
    while (mon < 12 && days >= month_length(mon, year_is_leap(yr))) begin
      days -= month_length(mon, year_is_leap(yr));
      mon++;
    end
    d.year         = yr[15:0];
    d.month        = mon[3:0];
    d.day_of_month = 5'(days + 1);
    d.hour         = 5'(sod / 3600);
    d.minute       = 6'((sod % 3600) / 60);
    d.second       = 6'(sod % 60);
    return d;
  endfunction

  function automatic int idle_phase(input int count);
    int p;
    p = (count * 3) / stim_total;
    return (p > 2) ? 2 : p;
  endfunction

  function automatic logic [39:0] random_timestamp();
    longint unsigned v;
    longint unsigned days;
    longint unsigned sod;
    int unsigned     kind;
    kind = $urandom_range(0, 99);
    sod  = $urandom_range(0, 86399);
    if (kind < 40) begin
      v = {$urandom, $urandom};
      return v[39:0];
    end else if (kind < 65) begin
      days = $urandom_range(0, 40000);
    end else if (kind < 85) begin
      days = $urandom_range(0, 87) * 146097 + $urandom_range(0, 146096);
      case ($urandom_range(0, 2))
        0:       sod = 0;
        1:       sod = 86399;
        default: ;
      endcase
    end else begin
      // around a 400-year boundary
      days = $urandom_range(1, 87) * 146097;
      if ($urandom_range(0, 1) != 0) days += $urandom_range(0, 800);
      else days -= $urandom_range(1, 800);
    end
    v = days * 86400 + sod;
    return v[39:0];
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // request driver
  always @(negedge clk) begin : drive
    int pct;
    pct = 0;
    case (idle_phase(requests_sent))
      0:       pct = 32;
      1:       pct = 49;
      default: pct = 0;
    endcase
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (requests_sent == PAUSE_AT && !pause_done && pending_dates.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        if (requests_sent == PAUSE_AT) pause_done = 1'b1;
        if (timestamp_backlog.size() != 0 && $urandom_range(0, 99) >= pct) begin
          in_valid      <= 1'b1;
          epoch_seconds <= timestamp_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_dates.push_back(seconds_to_date(epoch_seconds));
      requests_sent++;
      req_taken = 1'b1;
    end
  end

  // result side
  always @(negedge clk) begin : receive
    int pct;
    pct = 0;
    case (idle_phase(dates_received))
      0:       pct = 49;
      1:       pct = 32;
      default: pct = 0;
    endcase
    if (rst) begin
      out_ready <= 1'b0;
    end else if (dates_received == HOLD_AT && hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= pct);
    end
  end

  always @(posedge clk) begin : check
    calendar_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        $error("result with no request outstanding: %0d-%0d-%0d %0d:%0d:%0d",
               year, month, day_of_month, hour, minute, second);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year", want.year, year);
        check_field("month", want.month, month);
        check_field("day_of_month", want.day_of_month, day_of_month);
        check_field("hour", want.hour, hour);
        check_field("minute", want.minute, minute);
        check_field("second", want.second, second);
      end
      dates_received++;
    end
  end

  initial begin
    timestamp_backlog.push_back(40'd0);
    timestamp_backlog.push_back(40'd59);
    timestamp_backlog.push_back(40'd60);
    timestamp_backlog.push_back(40'd3599);
    timestamp_backlog.push_back(40'd3600);
    timestamp_backlog.push_back(40'd86399);
    timestamp_backlog.push_back(40'd86400);
    timestamp_backlog.push_back(40'd94694399);
    timestamp_backlog.push_back(40'd946684799);
    timestamp_backlog.push_back(40'd946684800);
    timestamp_backlog.push_back(40'd951782400);
    timestamp_backlog.push_back(40'd951868799);
    timestamp_backlog.push_back(40'd951868800);
    timestamp_backlog.push_back(40'd4107542399);
    timestamp_backlog.push_back(40'd4107542400);
    timestamp_backlog.push_back(40'd4294967295);
    timestamp_backlog.push_back(40'd4294967296);
    timestamp_backlog.push_back(40'd12622780799);
    timestamp_backlog.push_back(40'd12622780800);
    timestamp_backlog.push_back(40'd13574563200);
    timestamp_backlog.push_back(40'hAA_AAAA_AAAA);
    timestamp_backlog.push_back(40'h55_5555_5555);
    timestamp_backlog.push_back(40'hFF_FFFF_FFFF);
    for (int i = 0; i < N_RANDOM; i++) timestamp_backlog.push_back(random_timestamp());
    stim_total = timestamp_backlog.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (dates_received == stim_total);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ecal_pkg.sv
hdl/ecal_div.sv
hdl/ecal_dp.sv
hdl/ecal_ctrl.sv
hdl/epoch_seconds_to_calendar_top.sv
tb/tb_epoch_seconds_to_calendar_top.sv
